// File: rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper core.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

	// Largest supported ROM bank count, as log2.
	localparam int unsigned MAX_ROM_LOG2 = 9;
	// Largest supported RAM bank count, as log2.
	localparam int unsigned MAX_RAM_LOG2 = 4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAPPER_TYPE = 2'd0;
	localparam logic [1:0] CFG_ROM_LOG2    = 2'd1;
	localparam logic [1:0] CFG_RAM_LOG2    = 2'd2;
	localparam logic [1:0] CFG_RTC_PRESENT = 2'd3;

	typedef enum logic [2:0] {
		MAP_PLAIN     = 3'd0,
		MAP_TYPE1     = 3'd1,
		MAP_TYPE1_MC  = 3'd2,
		MAP_TYPE2     = 3'd3,
		MAP_TYPE3     = 3'd4,
		MAP_HUDSON1   = 3'd5,
		MAP_HUDSON3   = 3'd6,
		MAP_TYPE5     = 3'd7
	} mapper_t;

	typedef struct packed {
		mapper_t    mapper_type;
		logic [3:0] rom_log2;
		logic [2:0] ram_log2;
		logic       rtc_present;
	} cbm_cfg_t;

	typedef struct packed {
		logic [8:0] rom_bank;
		logic [7:0] ram_bank;
		logic       ram_enable;
		logic       bank_mode;
		logic [7:0] hudson_flag;
	} cbm_state_t;

	typedef struct packed {
		logic [8:0] rom_bank_register;
		logic [7:0] hudson_flag_out;
		logic [7:0] clock_latch_byte;
		logic       clock_latch_strobe;
		logic       clock_access_en;
		logic       ram_write_en;
		logic       ram_read_en;
		logic [3:0] ram_bank;
		logic [5:0] lower_rom_bank;
		logic [8:0] upper_rom_bank;
	} cbm_result_t;

endpackage

`default_nettype wire

// File: rtl/core/cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core
// Cartridge memory bank controller: one CPU ROM-window write in, one memory
// map report out.
// ----------------------------------------------------------------------------
// Each item on the slave stream is a CPU write into the 32 KiB ROM window.
// The core updates the bank registers of the mapper type selected through the
// configuration port and returns one result item with the resulting map:
// upper and lower ROM bank, RAM bank, RAM read/write and clock enables, clock
// latch strobe and byte, Hudson flag and the raw ROM bank register. One item
// is taken every clock cycle unless the master side stalls; an accepted write
// loads the input register, and its result is then loaded into the result
// register. The bank registers are
// read and written in the single decode step between those two registers,
// so back-to-back writes see each other's effect. A stalled master side holds
// the result register and, once the input register is also full, drops
// s_tready. Write configuration only while no item is in flight; the state
// is kept across a change of mapper type.
`default_nettype none

module cartridge_bank_mapper_core
	import cbm_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [3:0]  cfg_wdata,
	// write items
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [23:0] s_tdata,   // write_address[14:0], write_data[22:15], zero pad
	// result items
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [47:0] m_tdata   // upper_rom_bank[8:0], lower_rom_bank[14:9],
	                              // ram_bank[18:15], ram_read_en[19],
	                              // ram_write_en[20], clock_access_en[21],
	                              // clock_latch_strobe[22], clock_latch_byte[30:23],
	                              // hudson_flag_out[38:31], rom_bank_register[47:39]
);

	cbm_cfg_t    cfg_q;
	cbm_state_t  state_q;
	cbm_state_t  state_nxt;
	cbm_result_t res;

	logic        valid_s1;
	logic [14:0] addr_s1;
	logic [7:0]  data_s1;
	logic        advance_s1;
	logic        out_valid_q;
	cbm_result_t out_q;

	// Advance the input register whenever the result register is free or drains.
	assign advance_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;

	// Configuration registers; unknown indexes cannot occur with a 2-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_type <= MAP_PLAIN;
			cfg_q.rom_log2    <= 4'd1;
			cfg_q.ram_log2    <= 3'd0;
			cfg_q.rtc_present <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAPPER_TYPE: cfg_q.mapper_type <= mapper_t'(cfg_wdata[2:0]);
				CFG_ROM_LOG2:    cfg_q.rom_log2    <= cfg_wdata;
				CFG_RAM_LOG2:    cfg_q.ram_log2    <= cfg_wdata[2:0];
				CFG_RTC_PRESENT: cfg_q.rtc_present <= cfg_wdata[0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// Input register: hold the write until decode can pass it on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			addr_s1 <= s_tdata[14:0];
			data_s1 <= s_tdata[22:15];
		end
	end

	cbm_next u_next (
		.cfg           (cfg_q),
		.cur           (state_q),
		.write_address (addr_s1),
		.write_data    (data_s1),
		.nxt           (state_nxt),
		.res           (res)
	);

	// Bank registers commit together with the result they produce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank    <= 9'd1;
			state_q.ram_bank    <= 8'd0;
			state_q.ram_enable  <= 1'b0;
			state_q.bank_mode   <= 1'b0;
			state_q.hudson_flag <= 8'd0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on advance, clear valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item not held in input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(addr_s1) && $stable(data_s1))
		else $error("stalled input register changed");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> m_tvalid)
		else $error("decoded item lost before result register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_latch_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_q.clock_latch_strobe |-> out_q.clock_latch_byte == 8'd0)
		else $error("latch byte set without strobe");
`endif

endmodule

`default_nettype wire

// File: rtl/core/cbm_next.sv
// ----------------------------------------------------------------------------
// cbm_next
// Bank register update and memory map decode for one CPU write.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_next
	import cbm_pkg::*;
(
	input  wire cbm_cfg_t    cfg,
	input  wire cbm_state_t  cur,
	input  wire [14:0]       write_address,
	input  wire [7:0]        write_data,
	output cbm_state_t       nxt,
	output cbm_result_t      res
);

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_ROM    = 2'd1;
	localparam logic [1:0] REG_RAM    = 2'd2;
	localparam logic [1:0] REG_MODE   = 2'd3;

	localparam logic [7:0] HFLAG_RW       = 8'h0A;
	localparam logic [7:0] HFLAG_CLK_LO   = 8'h0B;
	localparam logic [7:0] HFLAG_CLK_END  = 8'h0F;
	localparam logic [7:0] HFLAG_RW_ABOVE = 8'h0D;
	localparam logic [7:0] CLK_BANK_LO    = 8'h08;
	localparam logic [7:0] CLK_BANK_HI    = 8'h0C;
	localparam logic [14:0] TYPE5_HI_ADDR = 15'h3000;

	localparam int unsigned ROM_W = MAX_ROM_LOG2 + 1;

	function automatic logic [8:0] zero_adjust9(input logic [8:0] b);
		zero_adjust9 = (b[4:0] == 5'd0) ? (b | 9'd1) : b;
	endfunction

	function automatic logic [8:0] at_least_one(input logic [8:0] b);
		at_least_one = (b == 9'd0) ? 9'd1 : b;
	endfunction

	logic [1:0]       region;
	logic             en_match;
	logic [3:0]       rom_n;
	logic [2:0]       ram_n;
	logic [ROM_W-1:0] rom_mask_w;
	logic [4:0]       ram_mask_w;
	logic [8:0]       rm;
	logic [3:0]       am;
	logic [5:0]       rb;

	assign region   = write_address[14:13];
	assign en_match = (write_data[3:0] == 4'hA);

	// Saturate the bank counts, then build the power-of-two masks.
	assign rom_n      = (cfg.rom_log2 > 4'(MAX_ROM_LOG2)) ? 4'(MAX_ROM_LOG2) : cfg.rom_log2;
	assign ram_n      = (cfg.ram_log2 > 3'(MAX_RAM_LOG2)) ? 3'(MAX_RAM_LOG2) : cfg.ram_log2;
	assign rom_mask_w = (ROM_W'(1) << rom_n) - ROM_W'(1);
	assign ram_mask_w = (5'd1 << ram_n) - 5'd1;
	assign rm         = rom_mask_w[8:0];
	assign am         = ram_mask_w[3:0];

	always_comb begin
		nxt = cur;
		res = '0;
		res.upper_rom_bank = 9'd1;
		rb = 6'd0;

		case (cfg.mapper_type)
			MAP_PLAIN: begin
				if (region == REG_ENABLE) nxt.ram_enable = en_match;
				res.ram_read_en  = nxt.ram_enable;
				res.ram_write_en = nxt.ram_enable;
			end
			MAP_TYPE1: begin
				case (region)
					REG_ENABLE: nxt.ram_enable = en_match;
					REG_ROM: begin
						nxt.rom_bank = cur.bank_mode ? {4'd0, write_data[4:0]}
							: {2'd0, cur.rom_bank[6:5], write_data[4:0]};
					end
					REG_RAM: begin
						if (cur.bank_mode) nxt.ram_bank = {6'd0, write_data[1:0]};
						else nxt.rom_bank = {2'd0, write_data[1:0], cur.rom_bank[4:0]};
					end
					default: nxt.bank_mode = write_data[0];
				endcase
				res.upper_rom_bank = zero_adjust9(nxt.rom_bank) & rm;
				res.ram_bank       = nxt.ram_bank[3:0] & am;
				res.ram_read_en    = nxt.ram_enable;
				res.ram_write_en   = nxt.ram_enable;
			end
			MAP_TYPE1_MC: begin
				case (region)
					REG_ENABLE: nxt.ram_enable = en_match;
					REG_ROM:    nxt.rom_bank = {2'd0, cur.rom_bank[6:5], write_data[4:0]};
					REG_RAM:    nxt.rom_bank = {2'd0, write_data[1:0], cur.rom_bank[4:0]};
					default:    nxt.bank_mode = write_data[0];
				endcase
				rb = {nxt.rom_bank[6:5], nxt.rom_bank[3:0]};
				if (nxt.bank_mode) begin
					// 64-bank multicart remap, not masked
					res.upper_rom_bank = zero_adjust9({3'd0, rb});
					res.lower_rom_bank = {rb[5:4], 4'd0};
				end else begin
					res.upper_rom_bank = zero_adjust9(nxt.rom_bank) & rm;
				end
				res.ram_read_en  = nxt.ram_enable;
				res.ram_write_en = nxt.ram_enable;
			end
			MAP_TYPE2: begin
				if (write_address[14:13] == 2'b00 && !write_address[8]) begin
					nxt.ram_enable = en_match;
				end else if (write_address[14:13] == 2'b01 && write_address[8]) begin
					nxt.rom_bank = {5'd0, write_data[3:0]};
				end
				res.upper_rom_bank = at_least_one({5'd0, nxt.rom_bank[3:0]}) & rm;
				res.ram_read_en    = nxt.ram_enable;
				res.ram_write_en   = nxt.ram_enable;
			end
			MAP_TYPE3: begin
				case (region)
					REG_ENABLE: nxt.ram_enable = en_match;
					REG_ROM:    nxt.rom_bank = {2'd0, write_data[6:0]};
					REG_RAM:    nxt.ram_bank = write_data;
					default: begin
						if (cfg.rtc_present) begin
							res.clock_latch_strobe = 1'b1;
							res.clock_latch_byte   = write_data;
						end
					end
				endcase
				res.upper_rom_bank  = at_least_one(nxt.rom_bank & rm);
				res.ram_bank        = nxt.ram_bank[3:0] & am;
				res.ram_read_en     = nxt.ram_enable;
				res.ram_write_en    = nxt.ram_enable;
				res.clock_access_en = cfg.rtc_present && nxt.ram_enable
					&& nxt.ram_bank >= CLK_BANK_LO && nxt.ram_bank <= CLK_BANK_HI;
			end
			MAP_HUDSON1: begin
				case (region)
					REG_ENABLE: nxt.ram_enable = en_match;
					REG_ROM:    nxt.rom_bank = {3'd0, write_data[5:0]};
					REG_RAM:    nxt.ram_bank = {6'd0, write_data[1:0]};
					default:    nxt.bank_mode = write_data[0];
				endcase
				res.upper_rom_bank = (nxt.bank_mode ? nxt.rom_bank
					: {1'b0, nxt.ram_bank[1:0], nxt.rom_bank[5:0]}) & rm;
				res.ram_bank     = nxt.bank_mode ? (nxt.ram_bank[3:0] & am) : 4'd0;
				res.ram_read_en  = 1'b1;
				res.ram_write_en = nxt.ram_enable;
			end
			MAP_HUDSON3: begin
				case (region)
					REG_ENABLE: nxt.hudson_flag = write_data;
					REG_ROM:    nxt.rom_bank = {1'b0, write_data};
					REG_RAM:    nxt.ram_bank = write_data;
					default:    nxt = nxt;
				endcase
				res.upper_rom_bank  = at_least_one(nxt.rom_bank & rm);
				res.ram_bank        = nxt.ram_bank[3:0] & am;
				res.hudson_flag_out = nxt.hudson_flag;
				res.ram_read_en     = 1'b1;
				if (nxt.hudson_flag >= HFLAG_CLK_LO && nxt.hudson_flag < HFLAG_CLK_END) begin
					res.ram_write_en    = 1'b1;
					res.clock_access_en = 1'b1;
				end else if (nxt.hudson_flag == HFLAG_RW
					|| nxt.hudson_flag > HFLAG_RW_ABOVE) begin
					res.ram_write_en = 1'b1;
				end
			end
			MAP_TYPE5: begin
				case (region)
					REG_ENABLE: nxt.ram_enable = en_match;
					REG_ROM: begin
						if (write_address < TYPE5_HI_ADDR) nxt.rom_bank = {cur.rom_bank[8], write_data};
						else nxt.rom_bank = {write_data[0], cur.rom_bank[7:0]};
					end
					REG_RAM: nxt.ram_bank = {4'd0, write_data[3:0]};
					default: nxt = nxt;
				endcase
				res.upper_rom_bank = nxt.rom_bank & rm;
				res.ram_bank       = nxt.ram_bank[3:0] & am;
				res.ram_read_en    = nxt.ram_enable;
				res.ram_write_en   = nxt.ram_enable;
			end
			default: begin
				res.ram_read_en  = cur.ram_enable;
				res.ram_write_en = cur.ram_enable;
			end
		endcase

		res.rom_bank_register = nxt.rom_bank;
	end

endmodule

`default_nettype wire
